### rtl/core/rbj_pkg.sv
package rbj_pkg;

    localparam int QW_BITS = 32;

    // Q16.16 pi and two pi.
    localparam int Q_PI_I     = 205887;
    localparam int Q_TWO_PI_I = 411774;

    localparam int NORM_STEPS   = 6;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 34;
    localparam int BDIV_STEPS   = 33;
    localparam int RDIV_STEPS   = 17;
    localparam int MOD_STEPS    = 14;

    // Register stage numbers; stage 1 holds the store read data.
    localparam int ST_DIFF  = 2;
    localparam int ST_ABS   = 3;
    localparam int ST_SUM   = 5;
    localparam int ST_CORD  = ST_ABS + NORM_STEPS;
    localparam int ST_ANG   = ST_CORD + CORDIC_STEPS + 1;
    localparam int ST_AABS  = ST_ANG + 1;
    localparam int ST_BEAR  = ST_AABS + MOD_STEPS + 1;
    localparam int ST_ROOT  = ST_SUM + SQRT_STEPS;
    localparam int ST_RDIV  = ST_ROOT + RDIV_STEPS;
    localparam int ST_SAT   = ST_RDIV + 1;
    localparam int ST_HP    = ST_SAT + 1;
    localparam int ST_T     = ST_HP + 1;
    localparam int ST_TH    = ST_T + 1;
    localparam int RBJ_LATENCY = ST_TH + 1;

    typedef enum logic [1:0] {
        CFG_NOISE_RR = 2'd0,
        CFG_NOISE_RB = 2'd1,
        CFG_NOISE_BR = 2'd2,
        CFG_NOISE_BB = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic               valid;
        logic               zero;
        logic               neg_x;
        logic               neg_y;
        logic               yneg;
        logic               ang_neg;
        logic               ang_oor;
        logic signed [20:0] z0;
        logic signed [31:0] heading;
        logic [32:0]        adx;
        logic [32:0]        ady;
        logic [3:0][31:0]   cov;
        logic [32:0]        qb_ady;
        logic [32:0]        qb_adx;
        logic [33:0]        d;
        logic signed [33:0] ang;
        logic [31:0]        bearing;
        logic [31:0]        rng;
        logic [3:0][31:0]   h;
    } t_side;

    function automatic logic signed [20:0] atan_lut(input int unsigned i);
        logic signed [20:0] v;
        case (i)
            0:  v = 21'sd51472;
            1:  v = 21'sd30386;
            2:  v = 21'sd16055;
            3:  v = 21'sd8150;
            4:  v = 21'sd4091;
            5:  v = 21'sd2047;
            6:  v = 21'sd1024;
            7:  v = 21'sd512;
            8:  v = 21'sd256;
            9:  v = 21'sd128;
            10: v = 21'sd64;
            11: v = 21'sd32;
            12: v = 21'sd16;
            13: v = 21'sd8;
            14: v = 21'sd4;
            15: v = 21'sd2;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Signed result from a sign and a quotient magnitude, saturated.
    function automatic logic [31:0] sat_quo(input logic neg, input logic [32:0] q);
        logic [32:0] nq;
        logic [31:0] r;
        nq = 33'd0 - q;
        if (q > 33'h0_8000_0000) begin
            r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (!neg) begin
            r = (q == 33'h0_8000_0000) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            r = nq[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/range_bearing_jacobian_unit_top.sv
// Range/bearing observation unit for a landmark filter.
// Command channel: a beat is taken at every clock edge where start is high
// and busy is low; busy is high only while reset is held, so a new beat can
// follow in every cycle. req_type 0 writes one landmark entry (mean and 2x2
// covariance) and gives no result. req_type 1 predicts range, bearing, the
// feature Jacobian and the innovation covariance for the indexed landmark
// and the given pose.
// Result channel: o_valid is high for one cycle per predict. Results leave in
// the order the predicts came in, one per cycle at most; the receiver cannot
// stall the unit.
// Throughput is one beat per clock. The latency is set by the square root
// (one result bit per stage, 34 stages) followed by the Jacobian dividers
// (17 stages) and four stages of 2x2 matrix products.
// The noise registers are written through the i_cfg port and must only be
// changed while no predict is in flight.
// Reset clears the pipeline valid bits and the noise registers; the landmark
// store is not cleared, so an entry must be written before it is used.
module range_bearing_jacobian_unit_top import rbj_pkg::*; #(
    parameter int LANDMARK_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_req_type,
    input  logic [7:0]         i_landmark_index,
    input  logic signed [31:0] i_vehicle_x,
    input  logic signed [31:0] i_vehicle_y,
    input  logic signed [31:0] i_vehicle_heading,
    input  logic signed [31:0] i_mark_x,
    input  logic signed [31:0] i_mark_y,
    input  logic signed [31:0] i_cov_in_xx,
    input  logic signed [31:0] i_cov_in_xy,
    input  logic signed [31:0] i_cov_in_yx,
    input  logic signed [31:0] i_cov_in_yy,
    output logic               o_valid,
    output logic signed [31:0] o_range,
    output logic signed [31:0] o_bearing,
    output logic signed [31:0] o_jac_range_dx,
    output logic signed [31:0] o_jac_range_dy,
    output logic signed [31:0] o_jac_bearing_dx,
    output logic signed [31:0] o_jac_bearing_dy,
    output logic signed [31:0] o_innov_xx,
    output logic signed [31:0] o_innov_xy,
    output logic signed [31:0] o_innov_yx,
    output logic signed [31:0] o_innov_yy,
    output logic               o_status
);

    localparam int LM_AW = (LANDMARK_DEPTH > 1) ? $clog2(LANDMARK_DEPTH) : 1;
    localparam int LM_DW = 6 * QW_BITS;

    // ---------------- configuration ----------------
    logic signed [31:0] r_noise [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_noise[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_NOISE_RR: r_noise[0] <= i_cfg_data;
                CFG_NOISE_RB: r_noise[1] <= i_cfg_data;
                CFG_NOISE_BR: r_noise[2] <= i_cfg_data;
                CFG_NOISE_BB: r_noise[3] <= i_cfg_data;
            endcase
        end
    end

    assign busy = !i_rst_n;

    // ---------------- store access ----------------
    logic [23:0]       idx_red;
    logic [LM_AW-1:0]  lm_addr;
    logic [LM_DW-1:0]  lm_rdata;

    // Index modulo the store depth by shifted compare and subtract.
    always_comb begin
        idx_red = 24'(i_landmark_index);
        for (int i = 7; i >= 0; i--) begin
            if (idx_red >= (24'(LANDMARK_DEPTH) << i)) begin
                idx_red = idx_red - (24'(LANDMARK_DEPTH) << i);
            end
        end
    end

    assign lm_addr = LM_AW'(idx_red);

    rbj_ram #(
        .WIDTH (LM_DW),
        .DEPTH (LANDMARK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (start && !busy && !i_req_type),
        .i_waddr (lm_addr),
        .i_wdata ({i_mark_x, i_mark_y, i_cov_in_xx, i_cov_in_xy,
                   i_cov_in_yx, i_cov_in_yy}),
        .i_raddr (lm_addr),
        .o_rdata (lm_rdata)
    );

    // ---------------- stage 1 and 2 ----------------
    logic               r_s1_valid;
    logic signed [31:0] r_s1_vx;
    logic signed [31:0] r_s1_vy;
    logic signed [31:0] r_s1_hd;
    logic signed [32:0] r_dx;
    logic signed [32:0] r_dy;
    t_side              n_side2;
    t_side              n_side [ST_DIFF:ST_TH];
    t_side              r_side [ST_DIFF:ST_TH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy && i_req_type;
        end
        r_s1_vx <= i_vehicle_x;
        r_s1_vy <= i_vehicle_y;
        r_s1_hd <= i_vehicle_heading;
        r_dx <= $signed({lm_rdata[191], lm_rdata[191:160]}) - $signed({r_s1_vx[31], r_s1_vx});
        r_dy <= $signed({lm_rdata[159], lm_rdata[159:128]}) - $signed({r_s1_vy[31], r_s1_vy});
    end

    always_comb begin
        n_side2         = '0;
        n_side2.valid   = r_s1_valid;
        n_side2.heading = r_s1_hd;
        n_side2.cov[0]  = lm_rdata[127:96];
        n_side2.cov[1]  = lm_rdata[95:64];
        n_side2.cov[2]  = lm_rdata[63:32];
        n_side2.cov[3]  = lm_rdata[31:0];
    end

    // ---------------- squares ----------------
    logic [65:0] r_sqx;
    logic [65:0] r_sqy;
    logic [66:0] r_s;

    always_ff @(posedge i_clk) begin
        r_sqx <= 66'(r_side[ST_ABS].adx) * 66'(r_side[ST_ABS].adx);
        r_sqy <= 66'(r_side[ST_ABS].ady) * 66'(r_side[ST_ABS].ady);
        r_s   <= 67'(r_sqx) + 67'(r_sqy);
    end

    // ---------------- square root, one bit per stage ----------------
    logic [68:0] r_sq_rem [SQRT_STEPS];
    logic [33:0] r_sq_res [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam int B = SQRT_STEPS - 1 - j;
        logic [68:0] rem_in;
        logic [33:0] res_in;
        logic [68:0] trial;
        logic        take;

        if (j == 0) begin : g_first
            assign rem_in = 69'(r_s);
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = r_sq_rem[j-1];
            assign res_in = r_sq_res[j-1];
        end

        assign trial = (69'(res_in) << (B + 1)) + (69'(1) << (2 * B));
        assign take  = (trial <= rem_in);

        always_ff @(posedge i_clk) begin
            r_sq_rem[j] <= take ? (rem_in - trial) : rem_in;
            r_sq_res[j] <= take ? (res_in | (34'(1) << B)) : res_in;
        end
    end

    // ---------------- dividers ----------------
    logic [32:0] qb_ady;
    logic [32:0] qb_adx;
    logic [16:0] qr_adx;
    logic [16:0] qr_ady;

    rbj_div_pipe #(.NW(65), .DW(67), .QW(BDIV_STEPS)) u_bdiv_y (
        .i_clk (i_clk),
        .i_num ({r_side[ST_SUM].ady, 32'd0}),
        .i_den (r_s),
        .o_quo (qb_ady)
    );

    rbj_div_pipe #(.NW(65), .DW(67), .QW(BDIV_STEPS)) u_bdiv_x (
        .i_clk (i_clk),
        .i_num ({r_side[ST_SUM].adx, 32'd0}),
        .i_den (r_s),
        .o_quo (qb_adx)
    );

    rbj_div_pipe #(.NW(49), .DW(34), .QW(RDIV_STEPS)) u_rdiv_x (
        .i_clk (i_clk),
        .i_num ({r_side[ST_ROOT].adx, 16'd0}),
        .i_den (r_sq_res[SQRT_STEPS-1]),
        .o_quo (qr_adx)
    );

    rbj_div_pipe #(.NW(49), .DW(34), .QW(RDIV_STEPS)) u_rdiv_y (
        .i_clk (i_clk),
        .i_num ({r_side[ST_ROOT].ady, 16'd0}),
        .i_den (r_sq_res[SQRT_STEPS-1]),
        .o_quo (qr_ady)
    );

    // ---------------- CORDIC operand normalization ----------------
    logic [40:0] r_nx [NORM_STEPS];
    logic [40:0] r_ny [NORM_STEPS];
    logic [40:0] r_nm [NORM_STEPS];

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic [40:0] x_in;
        logic [40:0] y_in;
        logic [40:0] m_in;
        logic        fits;

        if (j == 0) begin : g_first
            assign x_in = 41'(r_side[ST_ABS].adx);
            assign y_in = 41'(r_side[ST_ABS].ady);
            assign m_in = (r_side[ST_ABS].adx > r_side[ST_ABS].ady) ?
                          41'(r_side[ST_ABS].adx) : 41'(r_side[ST_ABS].ady);
        end else begin : g_next
            assign x_in = r_nx[j-1];
            assign y_in = r_ny[j-1];
            assign m_in = r_nm[j-1];
        end

        // Shift as long as the larger operand stays below 2^41.
        assign fits = ((m_in >> (41 - SH)) == 41'd0);

        always_ff @(posedge i_clk) begin
            r_nx[j] <= fits ? (x_in << SH) : x_in;
            r_ny[j] <= fits ? (y_in << SH) : y_in;
            r_nm[j] <= fits ? (m_in << SH) : m_in;
        end
    end

    // ---------------- CORDIC vectoring ----------------
    logic signed [43:0] r_cx [CORDIC_STEPS];
    logic signed [43:0] r_cy [CORDIC_STEPS];
    logic signed [20:0] r_cz [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cord
        logic signed [43:0] x_in;
        logic signed [43:0] y_in;
        logic signed [20:0] z_in;
        logic signed [43:0] xs;
        logic signed [43:0] ys;

        if (i == 0) begin : g_first
            assign x_in = $signed(44'(r_nx[NORM_STEPS-1]));
            assign y_in = r_side[ST_CORD].yneg ? -$signed(44'(r_ny[NORM_STEPS-1]))
                                               : $signed(44'(r_ny[NORM_STEPS-1]));
            assign z_in = r_side[ST_CORD].z0;
        end else begin : g_next
            assign x_in = r_cx[i-1];
            assign y_in = r_cy[i-1];
            assign z_in = r_cz[i-1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        always_ff @(posedge i_clk) begin
            if (y_in < 0) begin
                r_cx[i] <= x_in - ys;
                r_cy[i] <= y_in + xs;
                r_cz[i] <= z_in - atan_lut(i);
            end else begin
                r_cx[i] <= x_in + ys;
                r_cy[i] <= y_in - xs;
                r_cz[i] <= z_in + atan_lut(i);
            end
        end
    end

    // ---------------- angle reduction, one quotient bit per stage ----------------
    logic [32:0] r_md [MOD_STEPS];

    for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
        localparam logic [32:0] MS = 33'(Q_TWO_PI_I) << (MOD_STEPS - 1 - j);
        logic [32:0] r_in;

        if (j == 0) begin : g_first
            assign r_in = r_side[ST_AABS].ang_neg ? 33'(-r_side[ST_AABS].ang)
                                                  : 33'(r_side[ST_AABS].ang);
        end else begin : g_next
            assign r_in = r_md[j-1];
        end

        always_ff @(posedge i_clk) begin
            r_md[j] <= (r_in >= MS) ? (r_in - MS) : r_in;
        end
    end

    logic signed [34:0] bear_w;
    logic signed [34:0] bear_fix;

    always_comb begin
        if (r_side[ST_BEAR-1].ang_oor) begin
            bear_w = r_side[ST_BEAR-1].ang_neg ? -$signed({2'b00, r_md[MOD_STEPS-1]})
                                               : $signed({2'b00, r_md[MOD_STEPS-1]});
        end else begin
            bear_w = 35'(r_side[ST_BEAR-1].ang);
        end
        if (bear_w > 35'sd205887) begin
            bear_fix = bear_w - 35'(Q_TWO_PI_I);
        end else if (bear_w < -35'sd205887) begin
            bear_fix = bear_w + 35'(Q_TWO_PI_I);
        end else begin
            bear_fix = bear_w;
        end
    end

    // ---------------- side data pipeline ----------------
    always_comb begin
        n_side[ST_DIFF] = n_side2;
        for (int k = ST_DIFF + 1; k <= ST_TH; k++) begin
            n_side[k] = r_side[k-1];
        end

        n_side[ST_ABS].neg_x = r_dx[32];
        n_side[ST_ABS].neg_y = r_dy[32];
        n_side[ST_ABS].adx   = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
        n_side[ST_ABS].ady   = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);

        // Left half plane: flip the vector and start from plus or minus pi.
        n_side[ST_ABS+1].yneg = r_side[ST_ABS].neg_x ?
            (!r_side[ST_ABS].neg_y && (r_side[ST_ABS].ady != 33'd0)) :
            r_side[ST_ABS].neg_y;
        n_side[ST_ABS+1].z0 = !r_side[ST_ABS].neg_x ? 21'sd0 :
            (r_side[ST_ABS].neg_y ? -21'(Q_PI_I) : 21'(Q_PI_I));

        n_side[ST_SUM].zero = (r_sqx == 66'd0) && (r_sqy == 66'd0);

        n_side[ST_ANG].ang = 34'(r_cz[CORDIC_STEPS-1]) - 34'(r_side[ST_ANG-1].heading);
        n_side[ST_AABS].ang_neg = r_side[ST_ANG].ang[33];
        n_side[ST_AABS].ang_oor = (r_side[ST_ANG].ang > 34'sd205887) ||
                                  (r_side[ST_ANG].ang < -34'sd205887);
        n_side[ST_BEAR].bearing = bear_fix[31:0];

        n_side[ST_ROOT].qb_ady = qb_ady;
        n_side[ST_ROOT].qb_adx = qb_adx;
        n_side[ST_ROOT+1].d    = r_sq_res[SQRT_STEPS-1];

        n_side[ST_SAT].rng  = (r_side[ST_RDIV].d > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                     : r_side[ST_RDIV].d[31:0];
        n_side[ST_SAT].h[0] = sat_quo(r_side[ST_RDIV].neg_x, 33'(qr_adx));
        n_side[ST_SAT].h[1] = sat_quo(r_side[ST_RDIV].neg_y, 33'(qr_ady));
        n_side[ST_SAT].h[2] = sat_quo(!r_side[ST_RDIV].neg_y, r_side[ST_RDIV].qb_ady);
        n_side[ST_SAT].h[3] = sat_quo(r_side[ST_RDIV].neg_x, r_side[ST_RDIV].qb_adx);

        if (!i_rst_n) begin
            for (int k = ST_DIFF; k <= ST_TH; k++) begin
                n_side[k].valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = ST_DIFF; k <= ST_TH; k++) begin
            r_side[k] <= n_side[k];
        end
    end

    // ---------------- innovation covariance ----------------
    // Product index is 4*i + 2*j + k for row i, column j and inner term k.
    logic signed [63:0] r_hp [8];
    logic signed [31:0] r_t  [4];
    logic signed [63:0] r_tp [8];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                for (int k = 0; k < 2; k++) begin
                    r_hp[4*i+2*j+k] <= $signed(r_side[ST_SAT].h[2*i+k]) *
                                       $signed(r_side[ST_SAT].cov[2*k+j]);
                    r_tp[4*i+2*j+k] <= r_t[2*i+k] * $signed(r_side[ST_T].h[2*j+k]);
                end
                r_t[2*i+j] <= sat32((r_hp[4*i+2*j] >>> 16) + (r_hp[4*i+2*j+1] >>> 16));
            end
        end
    end

    // ---------------- output registers ----------------
    logic               r_o_valid;
    logic               r_o_status;
    logic [31:0]        r_o_fld [6];
    logic [31:0]        r_o_inn [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_o_status <= 1'b0;
        end else begin
            r_o_valid  <= r_side[ST_TH].valid;
            r_o_status <= r_side[ST_TH].valid && r_side[ST_TH].zero;
        end
        if (r_side[ST_TH].zero) begin
            for (int i = 0; i < 6; i++) begin
                r_o_fld[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_o_inn[i] <= '0;
            end
        end else begin
            r_o_fld[0] <= r_side[ST_TH].rng;
            r_o_fld[1] <= r_side[ST_TH].bearing;
            for (int i = 0; i < 4; i++) begin
                r_o_fld[2+i] <= r_side[ST_TH].h[i];
            end
            for (int i = 0; i < 4; i++) begin
                r_o_inn[i] <= sat32((r_tp[2*i] >>> 16) + (r_tp[2*i+1] >>> 16) +
                                    64'(r_noise[i]));
            end
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_range          = r_o_fld[0];
    assign o_bearing        = r_o_fld[1];
    assign o_jac_range_dx   = r_o_fld[2];
    assign o_jac_range_dy   = r_o_fld[3];
    assign o_jac_bearing_dx = r_o_fld[4];
    assign o_jac_bearing_dy = r_o_fld[5];
    assign o_innov_xx       = r_o_inn[0];
    assign o_innov_xy       = r_o_inn[1];
    assign o_innov_yx       = r_o_inn[2];
    assign o_innov_yy       = r_o_inn[3];

endmodule

### rtl/core/rbj_ram.sv
module rbj_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rbj_div_pipe.sv
// Restoring divider, one quotient bit per register stage. The top bits of
// the numerator above the quotient width must be below the denominator.
module rbj_div_pipe #(
    parameter int NW = 49,
    parameter int DW = 34,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int RW = DW + 1;

    logic [RW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar j = 0; j < QW; j++) begin : g_st
        logic [RW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] den_in;
        logic [RW-1:0] trial;
        logic          take;

        if (j == 0) begin : g_first
            assign rem_in = RW'(i_num[NW-1:QW]);
            assign low_in = i_num[QW-1:0];
            assign q_in   = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign low_in = r_low[j-1];
            assign q_in   = r_q[j-1];
            assign den_in = r_den[j-1];
        end

        assign trial = {rem_in[RW-2:0], low_in[QW-1]};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            r_rem[j] <= take ? (trial - {1'b0, den_in}) : trial;
            r_low[j] <= {low_in[QW-2:0], 1'b0};
            r_q[j]   <= {q_in[QW-2:0], take};
            r_den[j] <= den_in;
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

### rtl/core/rbj_chk.sv
module rbj_chk import rbj_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_req_type,
    input logic               o_valid,
    input logic               o_status,
    input logic signed [31:0] o_range,
    input logic signed [31:0] o_bearing
);

    // Every predict beat comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type) |-> ##RBJ_LATENCY o_valid)
        else $error("predict beat did not produce a result");

    // No result without a predict beat at the matching cycle.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_req_type, RBJ_LATENCY))
        else $error("result without a matching predict beat");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status |-> (o_valid && (o_range == 32'sd0) && (o_bearing == 32'sd0)))
        else $error("zero distance result carries nonzero fields");

    a_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_status) |->
            ((o_bearing <= 32'sd205887) && (o_bearing >= -32'sd205887)))
        else $error("bearing outside minus pi to pi");

endmodule

bind range_bearing_jacobian_unit_top rbj_chk u_rbj_chk (.*);

### tb/rbj_checker.sv
module rbj_checker import rbj_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_req_type,
    input  logic [7:0]         i_landmark_index,
    input  logic signed [31:0] i_vehicle_x,
    input  logic signed [31:0] i_vehicle_y,
    input  logic signed [31:0] i_vehicle_heading,
    input  logic signed [31:0] i_mark_x,
    input  logic signed [31:0] i_mark_y,
    input  logic signed [31:0] i_cov_in_xx,
    input  logic signed [31:0] i_cov_in_xy,
    input  logic signed [31:0] i_cov_in_yx,
    input  logic signed [31:0] i_cov_in_yy,
    input  logic               o_valid,
    input  logic signed [31:0] o_range,
    input  logic signed [31:0] o_bearing,
    input  logic signed [31:0] o_jac_range_dx,
    input  logic signed [31:0] o_jac_range_dy,
    input  logic signed [31:0] o_jac_bearing_dx,
    input  logic signed [31:0] o_jac_bearing_dy,
    input  logic signed [31:0] o_innov_xx,
    input  logic signed [31:0] o_innov_xy,
    input  logic signed [31:0] o_innov_yx,
    input  logic signed [31:0] o_innov_yy,
    input  logic               o_status,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic [31:0] field [10];
        logic        status;
    } t_obs;

    localparam string FIELD_NAME [10] = '{"range", "bearing", "jac_range_dx",
        "jac_range_dy", "jac_bearing_dx", "jac_bearing_dy", "innov_xx", "innov_xy",
        "innov_yx", "innov_yy"};
    localparam longint ATAN_Q [16] = '{51472, 30386, 16055, 8150, 4091, 2047,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

    logic [31:0] mark_x_mem [256];
    logic [31:0] mark_y_mem [256];
    logic [31:0] cov_mem    [256][4];
    logic [31:0] noise      [4];
    t_obs        obs_queue  [$];

    assign o_pending = obs_queue.size();

    function automatic logic [31:0] clamp32(longint v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] signed_quotient(logic neg, logic [127:0] q);
        logic [31:0] r;
        if (q > 128'h8000_0000) begin
            r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (!neg) begin
            r = (q == 128'h8000_0000) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            r = 32'd0 - q[31:0];
        end
        return r;
    endfunction

    function automatic longint bearing_of(longint dx, longint dy, logic signed [31:0] heading);
        longint x, y, z, xs, ys, ux, uy, sy, a;
        logic [63:0] m;
        int k;
        x = dx;
        y = dy;
        z = 0;
        k = 0;
        // Left half-plane: rotate by pi so the vectoring loop converges.
        if (dx < 0) begin
            z = (dy >= 0) ? Q_PI_I : -Q_PI_I;
            x = -dx;
            y = -dy;
        end
        sy = (y < 0) ? -1 : 1;
        ux = x;
        uy = (y < 0) ? -y : y;
        m = (ux > uy) ? ux : uy;
        while (((m << k) >> 40) == 0 && k < 48) k++;
        x = ux << k;
        y = sy * (uy << k);
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q[i];
            end
        end
        a = z - longint'(heading);
        if (a > Q_PI_I || a < -Q_PI_I) a = a % Q_TWO_PI_I;
        if (a > Q_PI_I) a = a - Q_TWO_PI_I;
        if (a < -Q_PI_I) a = a + Q_TWO_PI_I;
        return a;
    endfunction

    function automatic t_obs observe(logic [7:0] idx, logic signed [31:0] vx,
                                     logic signed [31:0] vy, logic signed [31:0] vh);
        t_obs o;
        longint dx, dy, adx, ady;
        longint h [4];
        longint p [4];
        longint t [4];
        logic [127:0] s, c, d;
        for (int i = 0; i < 10; i++) o.field[i] = '0;
        o.status = 1'b0;
        dx = longint'($signed(mark_x_mem[idx])) - longint'(vx);
        dy = longint'($signed(mark_y_mem[idx])) - longint'(vy);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        s = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
        if (s == 0) begin
            o.status = 1'b1;
            return o;
        end
        d = '0;
        for (int b = 33; b >= 0; b--) begin
            c = d | (128'd1 << b);
            if (c * c <= s) d = c;
        end
        o.field[0] = (d > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : d[31:0];
        o.field[1] = 32'(bearing_of(dx, dy, vh));
        o.field[2] = signed_quotient(dx < 0, (128'(adx) << 16) / d);
        o.field[3] = signed_quotient(dy < 0, (128'(ady) << 16) / d);
        o.field[4] = signed_quotient(dy > 0, (128'(ady) << 32) / s);
        o.field[5] = signed_quotient(dx < 0, (128'(adx) << 32) / s);
        for (int i = 0; i < 4; i++) begin
            h[i] = longint'($signed(o.field[2 + i]));
            p[i] = longint'($signed(cov_mem[idx][i]));
        end
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                t[2*i+j] = longint'($signed(clamp32(((h[2*i] * p[j]) >>> 16) +
                                                    ((h[2*i+1] * p[2+j]) >>> 16))));
            end
        end
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                o.field[6 + 2*i + j] = clamp32(((t[2*i] * h[2*j]) >>> 16) +
                    ((t[2*i+1] * h[2*j+1]) >>> 16) + longint'($signed(noise[2*i+j])));
            end
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_obs exp_obs;
        logic [31:0] got [10];
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) noise[i] <= '0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_NOISE_RR: noise[0] <= i_cfg_data;
                    CFG_NOISE_RB: noise[1] <= i_cfg_data;
                    CFG_NOISE_BR: noise[2] <= i_cfg_data;
                    CFG_NOISE_BB: noise[3] <= i_cfg_data;
                endcase
            end
            if (start && !busy) begin
                if (i_req_type == 1'b0) begin
                    mark_x_mem[i_landmark_index] <= i_mark_x;
                    mark_y_mem[i_landmark_index] <= i_mark_y;
                    cov_mem[i_landmark_index][0] <= i_cov_in_xx;
                    cov_mem[i_landmark_index][1] <= i_cov_in_xy;
                    cov_mem[i_landmark_index][2] <= i_cov_in_yx;
                    cov_mem[i_landmark_index][3] <= i_cov_in_yy;
                end else begin
                    obs_queue = {obs_queue, observe(i_landmark_index, i_vehicle_x,
                                                    i_vehicle_y, i_vehicle_heading)};
                end
            end
            if (o_valid) begin
                if (obs_queue.size() == 0) begin
                    $error("result beat with no predict outstanding");
                    errs++;
                end else begin
                    exp_obs = obs_queue.pop_front();
                    got = '{o_range, o_bearing, o_jac_range_dx, o_jac_range_dy,
                            o_jac_bearing_dx, o_jac_bearing_dy, o_innov_xx, o_innov_xy,
                            o_innov_yx, o_innov_yy};
                    for (int i = 0; i < 10; i++) begin
                        if (got[i] !== exp_obs.field[i]) begin
                            $error("%s: expected %0d, got %0d", FIELD_NAME[i],
                                   $signed(exp_obs.field[i]), $signed(got[i]));
                            errs++;
                        end
                    end
                    if (o_status !== exp_obs.status) begin
                        $error("status: expected %0d, got %0d", exp_obs.status, o_status);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

### tb/testbench.sv
module testbench;
    import rbj_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_req_type = 1'b0;
    logic [7:0]         i_landmark_index = '0;
    logic signed [31:0] i_vehicle_x = '0;
    logic signed [31:0] i_vehicle_y = '0;
    logic signed [31:0] i_vehicle_heading = '0;
    logic signed [31:0] i_mark_x = '0;
    logic signed [31:0] i_mark_y = '0;
    logic signed [31:0] i_cov_in_xx = '0;
    logic signed [31:0] i_cov_in_xy = '0;
    logic signed [31:0] i_cov_in_yx = '0;
    logic signed [31:0] i_cov_in_yy = '0;
    logic               o_valid;
    logic signed [31:0] o_range, o_bearing, o_jac_range_dx, o_jac_range_dy;
    logic signed [31:0] o_jac_bearing_dx, o_jac_bearing_dy;
    logic signed [31:0] o_innov_xx, o_innov_xy, o_innov_yx, o_innov_yy;
    logic               o_status;
    int                 fail_count;
    int                 pending;

    logic               written [256];
    logic signed [31:0] known_x [256];
    logic signed [31:0] known_y [256];
    int                 n_predicts = 0;
    int                 n_writes = 0;
    int                 stall_cycles = 0;
    bit                 allow_idle = 1'b1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    range_bearing_jacobian_unit_top dut (.*);

    rbj_checker checker_inst (.*, .o_fail_count(fail_count), .o_pending(pending));

    // Cycles without any beat moving count toward the stall limit.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] any_q(int unsigned sel);
        logic [31:0] v;
        case (sel % 6)
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = $urandom_range(0, 2_000_000) - 1_000_000;
            3: v = $urandom_range(0, 64) - 32;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic idle_maybe();
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic send_beat(logic req, logic [7:0] idx, logic [31:0] vx, logic [31:0] vy,
                             logic [31:0] vh, logic [31:0] mx, logic [31:0] my,
                             logic [31:0] cxx, logic [31:0] cxy, logic [31:0] cyx,
                             logic [31:0] cyy);
        start <= 1'b1;
        i_req_type <= req;
        i_landmark_index <= idx;
        i_vehicle_x <= vx;
        i_vehicle_y <= vy;
        i_vehicle_heading <= vh;
        i_mark_x <= mx;
        i_mark_y <= my;
        i_cov_in_xx <= cxx;
        i_cov_in_xy <= cxy;
        i_cov_in_yx <= cyx;
        i_cov_in_yy <= cyy;
        do @(posedge i_clk); while (busy);
        if (req) begin
            n_predicts++;
        end else begin
            n_writes++;
            written[idx] = 1'b1;
            known_x[idx] = mx;
            known_y[idx] = my;
        end
        idle_maybe();
    endtask

    task automatic store_mark(logic [7:0] idx, logic [31:0] mx, logic [31:0] my,
                              logic [31:0] cxx, logic [31:0] cxy, logic [31:0] cyx,
                              logic [31:0] cyy);
        send_beat(1'b0, idx, $urandom, $urandom, $urandom, mx, my, cxx, cxy, cyx, cyy);
    endtask

    task automatic observe_mark(logic [7:0] idx, logic [31:0] vx, logic [31:0] vy,
                                logic [31:0] vh);
        send_beat(1'b1, idx, vx, vy, vh, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
    endtask

    // Noise registers change only with the pipeline empty.
    task automatic set_noise(logic [31:0] rr, logic [31:0] rb, logic [31:0] br,
                             logic [31:0] bb);
        logic [31:0] vals [4];
        vals = '{rr, rb, br, bb};
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (RBJ_LATENCY + 4) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 2'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n_beats);
        logic [7:0] idx;
        logic [31:0] vx, vy;
        for (int n = 0; n < n_beats; n++) begin
            idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            if (!written[idx] || $urandom_range(0, 9) < 3) begin
                store_mark(idx, any_q($urandom), any_q($urandom), any_q($urandom),
                           any_q($urandom), any_q($urandom), any_q($urandom));
            end else begin
                // Mostly a vehicle near the landmark, sometimes anywhere.
                if ($urandom_range(0, 2) != 0) begin
                    vx = known_x[idx] + $urandom_range(0, 400_000) - 200_000;
                    vy = known_y[idx] + $urandom_range(0, 400_000) - 200_000;
                end else begin
                    vx = any_q($urandom);
                    vy = any_q($urandom);
                end
                observe_mark(idx, vx, vy, any_q($urandom));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 256; i++) written[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_noise(32'd65536, 32'd0, 32'd0, 32'd6554);
        // Directed: extremes, all quadrants, zero distance and heading wrap.
        store_mark(8'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF);
        store_mark(8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
        store_mark(8'd170, 32'd65536, 32'd131072, 32'd65536, 32'd0, 32'd0, 32'd65536);
        observe_mark(8'd0, 32'd0, 32'd0, 32'd0);
        observe_mark(8'd255, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        observe_mark(8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        observe_mark(8'd0, 32'd1, 32'd0, 32'h7FFF_FFFF);
        observe_mark(8'd0, 32'd0, 32'd1, 32'h8000_0000);
        observe_mark(8'd0, 32'd1, 32'd1, 32'd205887);
        observe_mark(8'd0, -32'sd1, -32'sd1, -32'sd205887);
        observe_mark(8'd0, 32'd65536, -32'sd65536, 32'd411774);
        observe_mark(8'd0, -32'sd65536, 32'd0, 32'd0);
        observe_mark(8'd170, 32'd0, 32'd0, 32'd100000);
        observe_mark(8'd170, 32'd131072, 32'd0, -32'sd300000);
        observe_mark(8'd170, 32'd65536, 32'd131072, 32'd0);
        observe_mark(8'd170, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);

        random_phase(100);
        set_noise(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        random_phase(100);
        set_noise(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        random_phase(100);
        set_noise($urandom, $urandom, $urandom, $urandom);
        allow_idle = 1'b0;
        random_phase(100);

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (RBJ_LATENCY + 8) @(posedge i_clk);
        $display("Covered %0d landmark writes and %0d predictions", n_writes, n_predicts);
        $display("under four noise settings, including both register extremes.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
